/* sv/sosc_pkg.sv */
// Shared types and constants for the shunt offset calibration and scaling block.
`timescale 1ns / 1ps

package sosc_pkg;

  localparam int RAW_W     = 12;
  localparam int CUR_W     = 16;
  localparam int SCALE_W   = 24;
  localparam int SUM_W     = 16;
  localparam int OFS_W     = 12;
  localparam int CH_N      = 4;
  localparam int CH_BUS    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_SCALE   = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  typedef logic [RAW_W-1:0] raw_t;

  typedef struct packed {
    raw_t raw_a;
    raw_t raw_b;
    raw_t raw_c;
    raw_t raw_bus;
  } in_item_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] current_a;
    logic signed [CUR_W-1:0] current_b;
    logic signed [CUR_W-1:0] current_c;
    logic signed [CUR_W-1:0] current_bus;
    logic                    calibrated;
  } out_item_t;

endpackage

/* sv/sosc_calib.sv */
// Offset accumulator and constant-divisor averaging for the four shunt channels.
`timescale 1ns / 1ps

module sosc_calib #(
  parameter int CALIB_SAMPLES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sosc_pkg::in_item_t item,
  output logic [sosc_pkg::OFS_W-1:0] offset [sosc_pkg::CH_N],
  output logic               item_cal
);
  import sosc_pkg::*;

  localparam int CNT_W  = (CALIB_SAMPLES > 1) ? $clog2(CALIB_SAMPLES) : 1;
  localparam int DIV_SH = SUM_W + 5;
  localparam int MUL_W  = DIV_SH + 1;
  localparam int DPR_W  = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((2 ** DIV_SH) + CALIB_SAMPLES - 1) / CALIB_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CALIB_SAMPLES - 1);

  logic [SUM_W-1:0] sum_r   [CH_N];
  logic [SUM_W-1:0] sum_nxt [CH_N];
  logic [OFS_W-1:0] offset_r [CH_N];
  logic [OFS_W-1:0] quot     [CH_N];
  logic [DPR_W-1:0] dprod    [CH_N];
  logic [CNT_W-1:0] cnt_r;
  logic             ready_r;
  logic             last;
  raw_t             raw [CH_N];

  assign raw[0] = item.raw_a;
  assign raw[1] = item.raw_b;
  assign raw[2] = item.raw_c;
  assign raw[3] = item.raw_bus;

  assign last     = !ready_r && (cnt_r == CNT_LAST);
  assign item_cal = ready_r || last;

  // The reciprocal is exact for every 16-bit sum and divisor up to 16.
  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      sum_nxt[ch] = sum_r[ch] + SUM_W'(raw[ch]);
      dprod[ch]   = DPR_W'(sum_nxt[ch]) * DPR_W'(DIV_MUL);
      quot[ch]    = dprod[ch][DIV_SH +: OFS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ready_r <= 1'b0;
      for (int ch = 0; ch < CH_N; ch++) begin
        sum_r[ch]    <= '0;
        offset_r[ch] <= '0;
      end
    end else if (load && !ready_r) begin
      for (int ch = 0; ch < CH_N; ch++) begin
        sum_r[ch] <= sum_nxt[ch];
      end
      if (last) begin
        ready_r <= 1'b1;
        for (int ch = 0; ch < CH_N; ch++) begin
          offset_r[ch] <= quot[ch];
        end
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign offset = offset_r;

`ifndef ASSERT_OFF
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |=> ready_r)
    else $error("calibration flag dropped");
  a_offsets_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |=> $stable(offset_r[0]) && $stable(offset_r[1]) &&
                $stable(offset_r[2]) && $stable(offset_r[3]))
    else $error("offsets changed after calibration");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("sample count beyond calibration length");
  a_last_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    load && last |=> ready_r)
    else $error("last calibration item did not set the flag");
`endif

endmodule

/* sv/shunt_offset_calibrate_and_scale_top.sv */
// Top level: input stage, offset calibration, scaling multiply and saturating output.
// One item per cycle sustained while out_stall is low.
// The ready path is a bubble-collapsing pipeline of four registered stages.
// Stage one sums and averages the offsets, stage three holds the scale products.
// Synchronous active-low reset clears all valids, counts, sums and offsets,
// and sets both scale registers to 65536; no clearing pass is needed.
`timescale 1ns / 1ps

module shunt_offset_calibrate_and_scale_top #(
  parameter int CALIB_SAMPLES = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sosc_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sosc_pkg::out_item_t                 out_item,
  input  logic                                cfg_wen,
  input  logic [sosc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sosc_pkg::SCALE_W-1:0]        cfg_wdata
);
  import sosc_pkg::*;

  localparam int DIFF_W = RAW_W + 1;
  localparam int SCS_W  = SCALE_W + 1;
  localparam int PROD_W = DIFF_W + SCS_W;
  localparam int SH_W   = PROD_W - FRAC_W;

  logic [SCALE_W-1:0] phase_scale_r;
  logic [SCALE_W-1:0] bus_scale_r;

  logic      v1_r, v2_r, v3_r, out_valid_r;
  logic      rdy1, rdy2, rdy3, rdy_out;
  in_item_t  raw1_r, raw2_r;
  logic      cal2_r, cal3_r;
  logic      item_cal;
  out_item_t out_item_r, out_item_nxt;

  logic [OFS_W-1:0]         offset  [CH_N];
  raw_t                     raw2    [CH_N];
  logic signed [DIFF_W-1:0] diff    [CH_N];
  logic signed [SCS_W-1:0]  scale_s [CH_N];
  logic signed [PROD_W-1:0] prod_nxt [CH_N];
  logic signed [PROD_W-1:0] prod_r   [CH_N];
  logic signed [SH_W-1:0]   shifted  [CH_N];
  logic signed [CUR_W-1:0]  cur      [CH_N];

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_scale_r <= SCALE_RESET;
      bus_scale_r   <= SCALE_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_PHASE_SCALE: phase_scale_r <= cfg_wdata;
        CFG_BUS_SCALE:   bus_scale_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      raw1_r <= in_item;
    end
  end

  sosc_calib #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_calib (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (v1_r && rdy2),
    .item     (raw1_r),
    .offset   (offset),
    .item_cal (item_cal)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      raw2_r <= raw1_r;
      cal2_r <= item_cal;
    end
  end

  assign raw2[0] = raw2_r.raw_a;
  assign raw2[1] = raw2_r.raw_b;
  assign raw2[2] = raw2_r.raw_c;
  assign raw2[3] = raw2_r.raw_bus;

  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      diff[ch]     = $signed({1'b0, raw2[ch]}) - $signed({1'b0, offset[ch]});
      scale_s[ch]  = (ch == CH_BUS) ? $signed({1'b0, bus_scale_r})
                                    : $signed({1'b0, phase_scale_r});
      prod_nxt[ch] = diff[ch] * scale_s[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      prod_r <= prod_nxt;
      cal3_r <= cal2_r;
    end
  end

  // Arithmetic shift gives floor rounding, then clamp to the 16-bit range; uncalibrated items give zero.
  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      shifted[ch] = prod_r[ch][PROD_W-1:FRAC_W];
      if (!cal3_r) begin
        cur[ch] = '0;
      end else if (!shifted[ch][SH_W-1] && (|shifted[ch][SH_W-2:CUR_W-1])) begin
        cur[ch] = {1'b0, {(CUR_W-1){1'b1}}};
      end else if (shifted[ch][SH_W-1] && !(&shifted[ch][SH_W-2:CUR_W-1])) begin
        cur[ch] = {1'b1, {(CUR_W-1){1'b0}}};
      end else begin
        cur[ch] = shifted[ch][CUR_W-1:0];
      end
    end
    out_item_nxt.current_a   = cur[0];
    out_item_nxt.current_b   = cur[1];
    out_item_nxt.current_c   = cur[2];
    out_item_nxt.current_bus = cur[3];
    out_item_nxt.calibrated  = cal3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v3_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_uncal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.calibrated |->
      out_item_r.current_a == '0 && out_item_r.current_b == '0 &&
      out_item_r.current_c == '0 && out_item_r.current_bus == '0)
    else $error("current reported before calibration");
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> !in_stall)
    else $error("input stalled with an empty input stage");
  a_cal_order: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && cal3_r && v2_r |-> cal2_r)
    else $error("calibrated item followed by an uncalibrated one");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the shunt offset calibration and current scaling block.
`timescale 1ns / 1ps

module testbench;
  import sosc_pkg::*;

  localparam int CALIB_SETS = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS = 250;
  localparam int PHASE_N = 8;
  localparam int ROW_N = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam in_item_t ALL_LOW = '0;
  localparam in_item_t ALL_HIGH = '1;
  localparam out_item_t NO_CURRENT = '0;
  localparam out_item_t ZERO_CAL = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1};
  localparam out_item_t SAT_LOW = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1};
  localparam out_item_t SAT_HIGH = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1};

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [SCALE_W-1:0]   reg_value;
    in_item_t             samples;
    bit                   typed;
    out_item_t            currents;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PHASE_SCALE;
  logic [SCALE_W-1:0]   cfg_wdata = '0;

  int  error_count = 0;
  int  cycle_count = 0;
  bit  steady_flow = 1'b0;
  bit  hold_request = 1'b0;

  int               calib_count = 0;
  logic [SUM_W-1:0] channel_sum [CH_N] = '{default: '0};
  bit               offsets_valid = 1'b0;
  logic [SCALE_W-1:0] phase_gain = SCALE_RESET;
  logic [SCALE_W-1:0] bus_gain = SCALE_RESET;

  out_item_t expected_currents [$];

  stim_row_t stim_table [ROW_N] = '{
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, ALL_LOW, 1'b1, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, ALL_HIGH, 1'b1, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2040, 12'd990, 12'd2990, 12'd290}, 1'b1, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2056, 12'd1010, 12'd3010, 12'd310}, 1'b1, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2040, 12'd990, 12'd2990, 12'd290}, 1'b1, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2056, 12'd1010, 12'd3010, 12'd310}, 1'b1, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2040, 12'd990, 12'd2990, 12'd290}, 1'b1, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2056, 12'd1010, 12'd3010, 12'd310}, 1'b1, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2040, 12'd990, 12'd2990, 12'd290}, 1'b1, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2056, 12'd1010, 12'd3010, 12'd310}, 1'b0, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, ALL_HIGH, 1'b0, NO_CURRENT},
    '{ROW_WRITE, CFG_PHASE_SCALE, 24'hffffff, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_WRITE, CFG_BUS_SCALE, 24'hffffff, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, ALL_LOW, 1'b1, SAT_LOW},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, ALL_HIGH, 1'b1, SAT_HIGH},
    '{ROW_WRITE, CFG_PHASE_SCALE, 24'h000000, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_WRITE, CFG_BUS_SCALE, 24'h000000, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'h5a5, 12'ha5a, 12'h0f0, 12'hf0f}, 1'b1, ZERO_CAL},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, ALL_HIGH, 1'b1, ZERO_CAL},
    '{ROW_WRITE, CFG_SPARE_LO, 24'hffffff, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_WRITE, CFG_SPARE_HI, 24'h010000, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2047, 12'd1209, 12'd2809, 12'd649}, 1'b1, ZERO_CAL},
    '{ROW_WRITE, CFG_PHASE_SCALE, 24'h000001, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_WRITE, CFG_BUS_SCALE, 24'h800000, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, ALL_HIGH, 1'b0, NO_CURRENT},
    '{ROW_ITEM, CFG_PHASE_SCALE, '0, '{12'd2048, 12'd1208, 12'd2810, 12'd650}, 1'b0, NO_CURRENT},
    '{ROW_WRITE, CFG_PHASE_SCALE, SCALE_RESET, ALL_LOW, 1'b0, NO_CURRENT},
    '{ROW_WRITE, CFG_BUS_SCALE, SCALE_RESET, ALL_LOW, 1'b0, NO_CURRENT}
  };

  shunt_offset_calibrate_and_scale_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shunt_offset_calibrate_and_scale_top test failed");
      $finish;
    end
  end

  function automatic logic signed [CUR_W-1:0] scale_to_current(raw_t raw,
      logic [SUM_W-1:0] offset, logic [SCALE_W-1:0] gain);
    longint diff;
    longint product;
    longint quotient;
    diff = longint'(raw) - longint'(offset);
    product = diff * longint'(gain);
    quotient = product >>> FRAC_W;
    if (quotient > 32767) quotient = 32767;
    if (quotient < -32768) quotient = -32768;
    return quotient[CUR_W-1:0];
  endfunction

  function automatic out_item_t predict_currents(in_item_t samples);
    raw_t      raws [CH_N];
    out_item_t result;
    raws = '{samples.raw_a, samples.raw_b, samples.raw_c, samples.raw_bus};
    result = NO_CURRENT;
    if (!offsets_valid) begin
      foreach (raws[i]) channel_sum[i] = channel_sum[i] + SUM_W'(raws[i]);
      if (calib_count + 1 >= CALIB_SETS) begin
        foreach (channel_sum[i]) channel_sum[i] = SUM_W'(channel_sum[i] / CALIB_SETS);
        offsets_valid = 1'b1;
      end else begin
        calib_count++;
      end
    end
    if (offsets_valid) begin
      result.current_a = scale_to_current(raws[0], channel_sum[0], phase_gain);
      result.current_b = scale_to_current(raws[1], channel_sum[1], phase_gain);
      result.current_c = scale_to_current(raws[2], channel_sum[2], phase_gain);
      result.current_bus = scale_to_current(raws[CH_BUS], channel_sum[CH_BUS], bus_gain);
      result.calibrated = 1'b1;
    end
    return result;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic raw_t pick_raw(logic [SUM_W-1:0] offset);
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) begin
      v = int'(offset) + int'($urandom_range(64)) - 32;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[RAW_W-1:0];
    end
    return RAW_W'($urandom_range(4095));
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return SCALE_RESET;
      3: return SCALE_W'($urandom_range(262144, 16384));
      4: return SCALE_W'($urandom_range(4096, 1));
      default: return SCALE_W'($urandom);
    endcase
  endfunction

  task automatic compare_field(input string name, input logic signed [CUR_W:0] want,
      input logic signed [CUR_W:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_currents.size() == 0) begin
      $error("item with no expectation waiting: %p", got);
      error_count++;
      return;
    end
    want = expected_currents.pop_front();
    compare_field("current_a", want.current_a, got.current_a);
    compare_field("current_b", want.current_b, got.current_b);
    compare_field("current_c", want.current_c, got.current_c);
    compare_field("current_bus", want.current_bus, got.current_bus);
    compare_field("calibrated", want.calibrated, got.calibrated);
  endtask

  task automatic offer_item(input in_item_t samples, input bit typed, input out_item_t typed_result);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_item <= samples;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_currents(samples);
    expected_currents.push_back(typed ? typed_result : predicted);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic settle_block();
    if (expected_currents.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_currents.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
      input logic [SCALE_W-1:0] value);
    settle_block();
    cfg_wen <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (index)
      CFG_PHASE_SCALE: phase_gain = value;
      CFG_BUS_SCALE: bus_gain = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic in_item_t random_samples();
    in_item_t samples;
    samples.raw_a = pick_raw(channel_sum[0]);
    samples.raw_b = pick_raw(channel_sum[1]);
    samples.raw_c = pick_raw(channel_sum[2]);
    samples.raw_bus = pick_raw(channel_sum[CH_BUS]);
    return samples;
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result(out_item);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 400;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(steady_flow);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    int burst_left;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        write_register(stim_table[i].reg_index, stim_table[i].reg_value);
      end else begin
        offer_item(stim_table[i].samples, stim_table[i].typed, stim_table[i].currents);
        idle_sender(pick_gap(1'b0));
      end
    end

    for (int phase = 0; phase < PHASE_N; phase++) begin
      write_register(CFG_PHASE_SCALE, pick_scale());
      write_register(CFG_BUS_SCALE, pick_scale());
      if (phase == 3) begin
        write_register($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                       SCALE_W'($urandom));
      end
      steady_flow = (phase == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 100) begin
          hold_request = 1'b1;
          burst_left = 40;
        end
        if (phase == 6 && n == 125) settle_block();
        offer_item(random_samples(), 1'b0, NO_CURRENT);
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          idle_sender(pick_gap(steady_flow));
        end
      end
    end
    steady_flow = 1'b0;

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("shunt_offset_calibrate_and_scale_top test passed");
    end else begin
      $display("shunt_offset_calibrate_and_scale_top test failed");
    end
    $finish;
  end

endmodule

/* shunt_offset_calibrate_and_scale_top.f */
sv/sosc_pkg.sv
sv/sosc_calib.sv
sv/shunt_offset_calibrate_and_scale_top.sv
bench/testbench.sv
